@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on aclk, off during reset
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("port check failed");

// next-cycle implication on aclk, off during reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("port check failed");

`endif

@@ hw/rtl/dmtlb_pkg.sv @@
`default_nettype none

package dmtlb_pkg;

    localparam int ENTRIES_DEF   = 64;
    localparam int PAGE_BITS_DEF = 12;

    localparam int ADDR_W    = 48;
    localparam int S_TDATA_W = 224;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 184;
    localparam int M_TUSER_W = 2;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_FILL   = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    localparam logic [1:0] KIND_INVALID = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_RETRY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic        pad;
        logic [7:0]  page_perms;
        logic [35:0] host_frame;
        logic [47:0] fill_page_address;
        logic        generation_stable;
        logic [31:0] live_generation;
        logic [31:0] request_generation;
        logic [1:0]  access_kind;
        logic [47:0] guest_address;
        logic [15:0] space_id;
    } in_data_t;

    typedef struct packed {
        logic [31:0] flush_count;
        logic [31:0] fault_count;
        logic [31:0] miss_count;
        logic [31:0] hit_count;
        logic [7:0]  perms_out;
        logic [47:0] host_address;
    } out_data_t;

endpackage

`default_nettype wire

@@ hw/rtl/direct_mapped_tlb.sv @@
// direct-mapped translation buffer tagged by address space and generation
// s_ channel: one command word per handshake (lookup, fill or whole-table flush),
//   command in s_tuser, request fields in s_tdata
// m_ channel: one result word per command, status in m_tuser, host address,
//   permissions and counters in m_tdata, always in command order
// stages: index fold, entry read, lookup/update, output reg; an accepted word
//   shows its result on m_tvalid once it has passed through all of them
// throughput: one word per cycle unless m_tready stalls the output; the entry
//   store is a single-port-write ram read one stage ahead, and an entry written
//   by one word is forwarded to the word right behind it
// reset: all entries invalid, counters zero, active space and generation zero,
//   pipeline empty; no clearing pass, the per-entry valid bits clear at once
// stall: while m_tready is low the result holds on m_tdata/m_tuser; the stages
//   behind it keep filling bubbles, and s_tready drops once all are occupied
// a change of address space or generation on a lookup with a nonzero space or on a well-formed fill clears the table
`default_nettype none

module direct_mapped_tlb #(
    parameter int ENTRIES   = dmtlb_pkg::ENTRIES_DEF,
    parameter int PAGE_BITS = dmtlb_pkg::PAGE_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // space_id, guest_address, access_kind, request_generation, live_generation,
    // generation_stable, fill_page_address, host_frame, page_perms, zero pad
    input  wire logic [dmtlb_pkg::S_TDATA_W-1:0] s_tdata,
    // command
    input  wire logic [dmtlb_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // host_address, perms_out, hit_count, miss_count, fault_count, flush_count
    output logic      [dmtlb_pkg::M_TDATA_W-1:0] m_tdata,
    // status
    output logic      [dmtlb_pkg::M_TUSER_W-1:0] m_tuser
);

    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int PN_W     = dmtlb_pkg::ADDR_W - PAGE_BITS;
    localparam int NDIG     = (PN_W + 3) / 4;
    localparam int DIG_BITS = NDIG * 4;
    localparam int SUM_W    = IDX_W + 4;
    localparam logic [dmtlb_pkg::ADDR_W-1:0] OFF_MASK =
        dmtlb_pkg::ADDR_W'((64'd1 << PAGE_BITS) - 64'd1);

    typedef struct packed {
        logic [15:0]     space;
        logic [PN_W-1:0] page;
        logic [35:0]     host;
        logic [31:0]     gen;
        logic [7:0]      perm;
        logic [2:0]      rights;
    } entry_t;

    localparam int WORD_W = $bits(entry_t);

    // pipeline control
    logic v1_reg, v2_reg, v3_reg, ov_reg;
    logic out_ready, rdy3, rdy2, rdy1, go3;

    // pipeline payload
    logic [dmtlb_pkg::S_TUSER_W-1:0] tuser1_reg, tuser2_reg, tuser3_reg;
    logic [dmtlb_pkg::S_TDATA_W-1:0] tdata1_reg, tdata2_reg, tdata3_reg;
    logic [SUM_W-1:0]                sum1_reg;
    logic [IDX_W-1:0]                idx2_reg, idx3_reg;
    entry_t                          fwd_word_reg;
    logic                            fwd_hit_reg, fwd_hit_next;
    logic [dmtlb_pkg::M_TDATA_W-1:0] out_tdata_reg;
    logic [dmtlb_pkg::M_TUSER_W-1:0] out_tuser_reg;

    // architectural state
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [15:0]        active_space_reg, active_space_next;
    logic [31:0]        active_gen_reg, active_gen_next;
    logic [31:0]        hit_reg [3];
    logic [31:0]        hit_next [3];
    logic [31:0]        miss_reg [3];
    logic [31:0]        miss_next [3];
    logic [31:0]        fault_reg, fault_next;
    logic [31:0]        flush_reg, flush_next;

    // index fold
    dmtlb_pkg::in_data_t s_in;
    logic [DIG_BITS-1:0] page_ext;
    logic [IDX_W-1:0]    dig_tbl [NDIG][16];
    logic [SUM_W-1:0]    sum_c;
    logic [SUM_W-1:0]    rem_c;

    // lookup/update stage
    dmtlb_pkg::in_data_t  d3;
    dmtlb_pkg::out_data_t out_next;
    logic [1:0]           status_next;
    entry_t               entry;
    entry_t               wdata;
    logic [WORD_W-1:0]    ram_rdata;
    logic                 we;
    logic [PN_W-1:0]      page3;
    logic [1:0]           kidx;
    logic                 kind_ok, ctx_mis, gen_bad, tag_eq, fill_bad;
    logic [2:0]           right_bit;

    assign out_ready = !ov_reg || m_tready;
    assign rdy3      = !v3_reg || out_ready;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign go3       = v3_reg && out_ready;
    assign s_tready  = rdy1;

    // page number mod ENTRIES as a sum of per-digit weights
    for (genvar p = 0; p < NDIG; p++) begin : g_dig
        for (genvar d = 0; d < 16; d++) begin : g_val
            localparam longint unsigned WEIGHT = (longint'(d) << (4 * p)) % ENTRIES;
            assign dig_tbl[p][d] = IDX_W'(WEIGHT);
        end
    end

    assign s_in     = dmtlb_pkg::in_data_t'(s_tdata);
    assign page_ext = DIG_BITS'(s_in.guest_address[dmtlb_pkg::ADDR_W-1:PAGE_BITS]);

    always_comb begin
        sum_c = '0;
        for (int p = 0; p < NDIG; p++) begin
            sum_c = sum_c + SUM_W'(dig_tbl[p][page_ext[4*p +: 4]]);
        end
    end

    always_comb begin
        rem_c = sum1_reg;
        for (int j = 1; j <= 8; j++) begin
            if (sum1_reg >= SUM_W'(j * ENTRIES)) begin
                rem_c = sum1_reg - SUM_W'(j * ENTRIES);
            end
        end
    end

    dmtlb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk     (aclk),
        .wr_en   (we),
        .wr_addr (idx3_reg),
        .wr_data (wdata),
        .rd_en   (rdy3),
        .rd_addr (idx2_reg),
        .rd_data (ram_rdata)
    );

    assign fwd_hit_next = we && (idx3_reg == idx2_reg);

    always_comb begin
        d3        = dmtlb_pkg::in_data_t'(tdata3_reg);
        entry     = fwd_hit_reg ? fwd_word_reg : entry_t'(ram_rdata);
        page3     = d3.guest_address[dmtlb_pkg::ADDR_W-1:PAGE_BITS];
        kidx      = d3.access_kind;
        kind_ok   = d3.access_kind != dmtlb_pkg::KIND_INVALID;
        right_bit = 3'(3'b001 << kidx);
        ctx_mis   = (active_space_reg != d3.space_id) ||
                    (active_gen_reg != d3.live_generation);
        gen_bad   = (d3.request_generation != d3.live_generation) ||
                    !d3.generation_stable;
        tag_eq    = valid_reg[idx3_reg] && !ctx_mis &&
                    (entry.space == d3.space_id) && (entry.page == page3) &&
                    (entry.gen == d3.request_generation);
        fill_bad  = (d3.space_id == 16'd0) || (d3.host_frame == 36'd0) ||
                    ((d3.guest_address & ~OFF_MASK) != d3.fill_page_address) ||
                    !kind_ok;

        valid_next        = valid_reg;
        active_space_next = active_space_reg;
        active_gen_next   = active_gen_reg;
        hit_next          = hit_reg;
        miss_next         = miss_reg;
        fault_next        = fault_reg;
        flush_next        = flush_reg;
        status_next       = dmtlb_pkg::ST_INVALID;
        out_next          = '0;
        we                = 1'b0;
        wdata             = entry;

        if (go3) begin
            unique case (tuser3_reg)
                dmtlb_pkg::CMD_LOOKUP: begin
                    if (d3.space_id == 16'd0) begin
                        fault_next = fault_reg + 32'd1;
                    end else begin
                        if (ctx_mis) begin
                            valid_next        = '0;
                            flush_next        = flush_reg + 32'd1;
                            active_space_next = d3.space_id;
                            active_gen_next   = d3.live_generation;
                        end
                        if (!gen_bad && kind_ok && tag_eq && entry.rights[kidx]) begin
                            hit_next[kidx]        = hit_reg[kidx] + 32'd1;
                            out_next.host_address = (dmtlb_pkg::ADDR_W'(entry.host)
                                                     << PAGE_BITS) |
                                                    (d3.guest_address & OFF_MASK);
                            out_next.perms_out    = entry.perm;
                            status_next           = dmtlb_pkg::ST_OK;
                        end else begin
                            if (kind_ok) begin
                                miss_next[kidx] = miss_reg[kidx] + 32'd1;
                            end else begin
                                fault_next = fault_reg + 32'd1;
                            end
                            status_next = gen_bad ? dmtlb_pkg::ST_RETRY
                                                  : dmtlb_pkg::ST_NOTFOUND;
                        end
                    end
                end
                dmtlb_pkg::CMD_FILL: begin
                    if (!fill_bad) begin
                        if (ctx_mis) begin
                            valid_next        = '0;
                            flush_next        = flush_reg + 32'd1;
                            active_space_next = d3.space_id;
                            active_gen_next   = d3.live_generation;
                        end
                        if (gen_bad) begin
                            status_next = dmtlb_pkg::ST_RETRY;
                        end else begin
                            if (tag_eq && (entry.host == d3.host_frame)) begin
                                wdata.perm   = d3.page_perms;
                                wdata.rights = entry.rights | right_bit;
                            end else begin
                                wdata.space  = d3.space_id;
                                wdata.page   = page3;
                                wdata.host   = d3.host_frame;
                                wdata.gen    = d3.request_generation;
                                wdata.perm   = d3.page_perms;
                                wdata.rights = right_bit;
                            end
                            we                   = 1'b1;
                            valid_next[idx3_reg] = 1'b1;
                            status_next          = dmtlb_pkg::ST_OK;
                        end
                    end
                end
                dmtlb_pkg::CMD_FLUSH: begin
                    valid_next        = '0;
                    active_space_next = '0;
                    active_gen_next   = '0;
                    flush_next        = flush_reg + 32'd1;
                    status_next       = dmtlb_pkg::ST_OK;
                end
                default: begin
                end
            endcase
        end

        out_next.hit_count   = kind_ok ? hit_next[kidx] : 32'd0;
        out_next.miss_count  = kind_ok ? miss_next[kidx] : 32'd0;
        out_next.fault_count = fault_next;
        out_next.flush_count = flush_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            ov_reg           <= 1'b0;
            fwd_hit_reg      <= 1'b0;
            valid_reg        <= '0;
            active_space_reg <= '0;
            active_gen_reg   <= '0;
            hit_reg          <= '{default: '0};
            miss_reg         <= '{default: '0};
            fault_reg        <= '0;
            flush_reg        <= '0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg      <= v2_reg;
                fwd_hit_reg <= fwd_hit_next;
            end
            if (out_ready) begin
                ov_reg <= go3;
            end
            valid_reg        <= valid_next;
            active_space_reg <= active_space_next;
            active_gen_reg   <= active_gen_next;
            hit_reg          <= hit_next;
            miss_reg         <= miss_next;
            fault_reg        <= fault_next;
            flush_reg        <= flush_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            tuser1_reg <= s_tuser;
            tdata1_reg <= s_tdata;
            sum1_reg   <= sum_c;
        end
        if (rdy2) begin
            tuser2_reg <= tuser1_reg;
            tdata2_reg <= tdata1_reg;
            idx2_reg   <= IDX_W'(rem_c);
        end
        if (rdy3) begin
            tuser3_reg   <= tuser2_reg;
            tdata3_reg   <= tdata2_reg;
            idx3_reg     <= idx2_reg;
            fwd_word_reg <= wdata;
        end
        if (go3) begin
            out_tdata_reg <= out_next;
            out_tuser_reg <= status_next;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = out_tdata_reg;
    assign m_tuser  = out_tuser_reg;

endmodule

`default_nettype wire

@@ hw/rtl/dmtlb_ram.sv @@
`default_nettype none

module dmtlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/dmtlb_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module dmtlb_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [dmtlb_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [dmtlb_pkg::M_TUSER_W-1:0] m_tuser
);

    dmtlb_pkg::out_data_t m_view;
    logic [2:0]           pend_reg, pend_next;
    logic                 in_acc, out_acc;

    assign m_view  = dmtlb_pkg::out_data_t'(m_tdata);
    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // words accepted but not yet delivered
    assign pend_next = 3'(pend_reg + {2'b00, in_acc} - {2'b00, out_acc});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `ASSERT_SAME(a_no_data_on_fail, m_tvalid && (m_tuser != dmtlb_pkg::ST_OK), (m_view.host_address == 48'd0) && (m_view.perms_out == 8'd0))
    `ASSERT_SAME(a_depth_bound, 1'b1, pend_reg <= 3'd4)
    `ASSERT_SAME(a_no_orphan, m_tvalid, pend_reg != 3'd0)

endmodule

bind direct_mapped_tlb dmtlb_checker u_dmtlb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
